/* hdl/vertex_motion_intensity_top_defines.svh */
// Assertion macros used by the checker file of the vertex motion intensity block.
`ifndef VERTEX_MOTION_INTENSITY_TOP_DEFINES_SVH
`define VERTEX_MOTION_INTENSITY_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define VMI_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("vertex motion intensity check failed");

// Next-cycle implication, ignored while reset is high.
`define VMI_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("vertex motion intensity check failed");

// Next-cycle implication that is also checked across reset.
`define VMI_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("vertex motion intensity check failed");

`endif

/* hdl/vmi_pkg.sv */
// Shared types and constants of the vertex motion intensity block.
`default_nettype none

package vmi_pkg;

   localparam int COORD_W    = 24;
   localparam int IDX_W      = 12;
   localparam int CFG_W      = 24;
   localparam int GAIN_W     = 16;
   localparam int RATIO_W    = 16;
   localparam int MAG_W      = COORD_W + 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int NUM_W      = CFG_W + RATIO_W;
   localparam int PROD_W     = RATIO_W + GAIN_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = 2;
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_GAIN = 2'd2;

   // Full scale of a Q0.16 ratio.
   localparam logic [RATIO_W-1:0] ONE_Q16 = 16'hFFFF;

   typedef struct packed {
      logic [IDX_W-1:0]          vertex_index;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } vmi_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic [RATIO_W-1:0] speed_ratio;
      logic [RATIO_W-1:0] intensity;
   } vmi_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]  max_speed;
      logic [CFG_W-1:0]  min_speed;
      logic [GAIN_W-1:0] color_gain;
   } vmi_cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] vertex_index;
      logic [SUM_W-1:0] sum;
   } vmi_mid_type;

endpackage

`default_nettype wire

/* hdl/vmi_front.sv */
// Front end: accepts vertices, updates the previous-position store, forms squared distance.
`default_nettype none

module vmi_front #(
   parameter int VERTEX_COUNT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  vmi_pkg::vmi_req_type req_payload,
   output logic                req_stall,
   output logic                mid_push,
   output vmi_pkg::vmi_mid_type mid_item,
   input  logic                mid_full
);
   import vmi_pkg::*;

   localparam int SLOT_W      = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP       = (1 << RECIP_SHIFT) / VERTEX_COUNT;
   localparam int RPROD_W     = IDX_W + RECIP_SHIFT + 1;
   localparam int QV_W        = IDX_W + 32;
   localparam int MEM_W       = 3 * COORD_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VERTEX_COUNT - 1);

   logic                  clr_ff, clr_in;
   logic [SLOT_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  en, accept;
   logic [RPROD_W-1:0]    rprod;
   logic [QV_W-1:0]       qv;
   logic [IDX_W-1:0]      rem_raw, rem_fix;

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                  s4_valid_ff, s5_valid_ff, s6_valid_ff;
   vmi_req_type           s1_item_ff, s2_item_ff, s3_item_ff;
   logic [IDX_W-1:0]      s1_q_ff;
   logic [SLOT_W-1:0]     s2_slot_ff;
   logic [MEM_W-1:0]      s3_old_ff;
   logic [IDX_W-1:0]      s4_idx_ff, s5_idx_ff, s6_idx_ff;
   logic [MAG_W-1:0]      s4_mag_ff [3];
   logic [SQ_W-1:0]       s5_sq_ff  [3];
   logic [SUM_W-1:0]      s6_sum_ff;
   logic [MEM_W-1:0]      mem [VERTEX_COUNT];

   // Magnitude of the difference of two coordinates.
   function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W+1:0] d;
      d = (COORD_W+2)'(a) - (COORD_W+2)'(b);
      if (d[COORD_W+1]) begin
         d = -d;
      end
      return d[MAG_W-1:0];
   endfunction

   // The whole front pipeline moves unless its last stage is blocked by a full queue.
   assign en        = !(s6_valid_ff && mid_full);
   assign req_stall = clr_ff || !en;
   assign accept    = req_valid && !req_stall;

   // Clearing pass over the store after reset.
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
         if (clr_cnt_ff == LAST_SLOT) begin
            clr_in = 1'b0;
         end
      end
   end

   // Slot is the index modulo the store depth, by reciprocal multiply and one correction.
   assign rprod = RPROD_W'(req_payload.vertex_index) * RPROD_W'(RECIP);
   assign qv    = QV_W'(s1_q_ff) * QV_W'(VERTEX_COUNT);
   always_comb begin
      rem_raw = s1_item_ff.vertex_index - qv[IDX_W-1:0];
      rem_fix = rem_raw;
      if (32'(rem_raw) >= 32'(VERTEX_COUNT)) begin
         rem_fix = rem_raw - IDX_W'(VERTEX_COUNT);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         if (en) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   // Store: read the old position and write the new one in the same cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         s3_old_ff <= mem[s2_slot_ff];
      end
      if (clr_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (en && s2_valid_ff) begin
         mem[s2_slot_ff] <= {s2_item_ff.pos_x, s2_item_ff.pos_y, s2_item_ff.pos_z};
      end
   end

   // Payload stages: slot, differences, squares, sum.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= req_payload;
         s1_q_ff    <= rprod[RECIP_SHIFT+IDX_W-1:RECIP_SHIFT];
         s2_item_ff <= s1_item_ff;
         s2_slot_ff <= SLOT_W'(rem_fix);
         s3_item_ff <= s2_item_ff;
         s4_idx_ff  <= s3_item_ff.vertex_index;
         s4_mag_ff[0] <= abs_diff(s3_item_ff.pos_x, s3_old_ff[3*COORD_W-1:2*COORD_W]);
         s4_mag_ff[1] <= abs_diff(s3_item_ff.pos_y, s3_old_ff[2*COORD_W-1:COORD_W]);
         s4_mag_ff[2] <= abs_diff(s3_item_ff.pos_z, s3_old_ff[COORD_W-1:0]);
         s5_idx_ff  <= s4_idx_ff;
         for (int k = 0; k < 3; k++) begin
            s5_sq_ff[k] <= SQ_W'(s4_mag_ff[k]) * SQ_W'(s4_mag_ff[k]);
         end
         s6_idx_ff  <= s5_idx_ff;
         s6_sum_ff  <= SUM_W'(s5_sq_ff[0]) + SUM_W'(s5_sq_ff[1]) + SUM_W'(s5_sq_ff[2]);
      end
   end

   assign mid_push              = s6_valid_ff && !mid_full;
   assign mid_item.vertex_index = s6_idx_ff;
   assign mid_item.sum          = s6_sum_ff;

endmodule

`default_nettype wire

/* hdl/vmi_queue.sv */
// Short queue between the front end and the back end.
`default_nettype none

module vmi_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vmi_pkg::vmi_mid_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output vmi_pkg::vmi_mid_type pop_item
);
   import vmi_pkg::*;

   vmi_mid_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/vmi_back.sv */
// Back end: square root, ratio division, gain scaling and the result register.
`default_nettype none

module vmi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  vmi_pkg::vmi_cfg_type cfg,
   input  logic                 mid_valid,
   input  vmi_pkg::vmi_mid_type mid_item,
   output logic                 mid_pop,
   output logic                 rsp_valid,
   output vmi_pkg::vmi_rsp_type rsp_payload,
   input  logic                 rsp_stall
);
   import vmi_pkg::*;

   localparam int EST_W = RATIO_W + 1;
   localparam int CORR_W = PROD_W + 3;

   logic                en;
   logic [CFG_W-1:0]    top;

   // Square root stages.
   logic                sq_valid_ff [0:ROOT_W];
   logic [IDX_W-1:0]    sq_idx_ff   [0:ROOT_W];
   logic [SUM_W-1:0]    sq_n_ff     [0:ROOT_W];
   logic [SUM_W-1:0]    sq_res_ff   [0:ROOT_W];

   // Division stages; stage zero holds the scaled numerator.
   logic                dv_valid_ff [0:RATIO_W];
   logic [IDX_W-1:0]    dv_idx_ff   [0:RATIO_W];
   logic [NUM_W-1:0]    dv_rem_ff   [0:RATIO_W];
   logic [RATIO_W-1:0]  dv_q_ff     [0:RATIO_W];

   logic [ROOT_W-1:0]   root_q;
   logic [CFG_W-1:0]    m;
   logic [NUM_W-1:0]    num;

   logic                p_valid_ff, e_valid_ff, rsp_valid_ff;
   logic [IDX_W-1:0]    p_idx_ff, e_idx_ff;
   logic [RATIO_W-1:0]  p_ratio_ff, e_ratio_ff;
   logic [PROD_W-1:0]   p_prod_ff, e_prod_ff;
   logic [EST_W-1:0]    e_q_ff;
   logic [PROD_W:0]     est_sum;
   logic [CORR_W-1:0]   corr;
   logic [EST_W:0]      inten_q;
   vmi_rsp_type         rsp_ff;

   // Everything moves together unless a finished result is waiting.
   assign en      = !rsp_valid_ff || !rsp_stall;
   assign mid_pop = en && mid_valid;
   assign top     = (cfg.max_speed == '0) ? CFG_W'(1) : cfg.max_speed;

   // Entry of the square root pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= mid_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq_idx_ff[0] <= mid_item.vertex_index;
         sq_n_ff[0]   <= mid_item.sum;
         sq_res_ff[0] <= '0;
      end
   end

   // One result bit per stage of the digit-by-digit square root.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
      logic [SUM_W-1:0] trial;
      assign trial = sq_res_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_idx_ff[k+1] <= sq_idx_ff[k];
            if (sq_n_ff[k] >= trial) begin
               sq_n_ff[k+1]   <= sq_n_ff[k] - trial;
               sq_res_ff[k+1] <= (sq_res_ff[k] >> 1) + BIT;
            end else begin
               sq_n_ff[k+1]   <= sq_n_ff[k];
               sq_res_ff[k+1] <= sq_res_ff[k] >> 1;
            end
         end
      end
   end

   // Clamp to full scale, apply the low threshold and scale to Q0.16.
   always_comb begin
      root_q = sq_res_ff[ROOT_W][ROOT_W-1:0];
      m      = (root_q < ROOT_W'(top)) ? root_q[CFG_W-1:0] : top;
      num    = '0;
      if (m >= cfg.min_speed) begin
         num = NUM_W'(m) * NUM_W'(ONE_Q16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sq_valid_ff[ROOT_W];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dv_idx_ff[0] <= sq_idx_ff[ROOT_W];
         dv_rem_ff[0] <= num;
         dv_q_ff[0]   <= '0;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 0; k < RATIO_W; k++) begin : g_div
      logic [NUM_W-1:0] dsr;
      assign dsr = NUM_W'(top) << (RATIO_W - 1 - k);
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_idx_ff[k+1] <= dv_idx_ff[k];
            if (dv_rem_ff[k] >= dsr) begin
               dv_rem_ff[k+1] <= dv_rem_ff[k] - dsr;
               dv_q_ff[k+1]   <= dv_q_ff[k] | (RATIO_W'(1) << (RATIO_W - 1 - k));
            end else begin
               dv_rem_ff[k+1] <= dv_rem_ff[k];
               dv_q_ff[k+1]   <= dv_q_ff[k];
            end
         end
      end
   end

   // Division of the gain product by 65535: estimate, then one correction step.
   assign est_sum = (PROD_W+1)'(p_prod_ff) + (PROD_W+1)'(p_prod_ff >> RATIO_W)
                  + (PROD_W+1)'(1);
   always_comb begin
      corr    = CORR_W'(e_prod_ff) + CORR_W'(e_q_ff) - (CORR_W'(e_q_ff) << RATIO_W);
      inten_q = (EST_W+1)'(e_q_ff);
      if (corr[CORR_W-1]) begin
         inten_q = (EST_W+1)'(e_q_ff) - (EST_W+1)'(1);
      end else if (corr >= CORR_W'(ONE_Q16)) begin
         inten_q = (EST_W+1)'(e_q_ff) + (EST_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff   <= dv_valid_ff[RATIO_W];
         e_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_idx_ff   <= dv_idx_ff[RATIO_W];
         p_ratio_ff <= dv_q_ff[RATIO_W];
         p_prod_ff  <= PROD_W'(dv_q_ff[RATIO_W]) * PROD_W'(cfg.color_gain);
         e_idx_ff   <= p_idx_ff;
         e_ratio_ff <= p_ratio_ff;
         e_prod_ff  <= p_prod_ff;
         e_q_ff     <= est_sum[PROD_W:RATIO_W];
         rsp_ff.out_index   <= e_idx_ff;
         rsp_ff.speed_ratio <= e_ratio_ff;
         rsp_ff.intensity   <= (inten_q > (EST_W+1)'(ONE_Q16)) ? ONE_Q16
                                                              : inten_q[RATIO_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* hdl/vertex_motion_intensity_top.sv */
// Top level of the vertex motion intensity block: registers and the two halves.
// Each accepted vertex yields one result giving its motion since the last time the same
// vertex index was seen, as a Q0.16 ratio of distance to max_speed and a gained Q8.8
// intensity. The block takes one vertex per clock cycle while req_stall is low. A vertex
// passes six front stages, the queue, 27 square root stages, 17 divider stages, two gain
// stages and the result register. After reset, the previous-position store is zeroed by
// a sweep over all VERTEX_COUNT entries while req_stall stays high. The user must write
// registers only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module vertex_motion_intensity_top #(
   parameter int VERTEX_COUNT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  vmi_pkg::vmi_req_type                 req_payload,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   output vmi_pkg::vmi_rsp_type                 rsp_payload,
   input  logic                                 rsp_stall,
   input  logic                                 csr_write_en,
   input  logic [vmi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vmi_pkg::CFG_W-1:0]            csr_wdata
);
   import vmi_pkg::*;

   vmi_cfg_type cfg_ff;
   logic        mid_push, mid_full, mid_pop, mid_valid;
   vmi_mid_type mid_push_item, mid_pop_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed  <= CFG_W'(2560);
         cfg_ff.min_speed  <= CFG_W'(128);
         cfg_ff.color_gain <= GAIN_W'(256);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MAX_SPEED:  cfg_ff.max_speed  <= csr_wdata;
            REG_MIN_SPEED:  cfg_ff.min_speed  <= csr_wdata;
            REG_COLOR_GAIN: cfg_ff.color_gain <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   vmi_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .mid_push    (mid_push),
      .mid_item    (mid_push_item),
      .mid_full    (mid_full)
   );

   vmi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_item (mid_push_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_valid (mid_valid),
      .pop_item  (mid_pop_item)
   );

   vmi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .mid_valid   (mid_valid),
      .mid_item    (mid_pop_item),
      .mid_pop     (mid_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

/* hdl/vmi_checker.sv */
// Port-level checks of the vertex motion intensity block and their binding.
`default_nettype none

`include "vertex_motion_intensity_top_defines.svh"

module vmi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input vmi_pkg::vmi_rsp_type          rsp_payload,
   input logic                          rsp_stall
);
   import vmi_pkg::*;

   logic zero_ratio;

   assign zero_ratio = (rsp_payload.speed_ratio == '0);

   // The store sweep holds off new vertices right after reset.
   `VMI_ASSERT_NEXT_ALWAYS(a_clear_holds_input, clock, reset, req_stall)
   // No motion means no intensity, whatever the gain.
   `VMI_ASSERT_IMPLY(a_zero_ratio_dark, clock, reset, rsp_valid && zero_ratio, rsp_payload.intensity == '0)
   // A waiting result stays offered.
   `VMI_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // A waiting result does not change.
   `VMI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

endmodule

bind vertex_motion_intensity_top vmi_checker u_vmi_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench of the vertex motion intensity block.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import vmi_pkg::*;

   localparam int VERTICES = 4096;
   localparam int RESULT_LATENCY = 80;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int NOISE_TAIL = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   vmi_req_type req_payload = '0;
   logic req_stall;
   logic rsp_valid;
   vmi_rsp_type rsp_payload;
   logic rsp_stall = 1'b0;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_MAX_SPEED;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Predictor state: registers and the previous positions of every vertex.
   logic [CFG_W-1:0] max_speed_q;
   logic [CFG_W-1:0] min_speed_q;
   logic [GAIN_W-1:0] color_gain_q;
   logic signed [COORD_W-1:0] last_x [VERTICES];
   logic signed [COORD_W-1:0] last_y [VERTICES];
   logic signed [COORD_W-1:0] last_z [VERTICES];

   // Positions as planned by the stimulus, to aim small moves.
   logic signed [COORD_W-1:0] last_x_plan [VERTICES];
   logic signed [COORD_W-1:0] last_y_plan [VERTICES];
   logic signed [COORD_W-1:0] last_z_plan [VERTICES];

   vmi_req_type pending_vertices[$];
   vmi_rsp_type expected_intensities[$];
   int mismatch_count = 0;
   int hold_cycles = 0;
   int send_gap = 0;
   int stall_burst = 0;
   bit idling_on = 1'b1;
   bit failed = 1'b0;
   longint cycle_count = 0;

   vertex_motion_intensity_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_payload(req_payload), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_payload(rsp_payload), .rsp_stall(rsp_stall),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Integer square root, rounded down.
   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Computes the motion result of one vertex and updates its stored position.
   function automatic vmi_rsp_type motion_of(vmi_req_type v);
      vmi_rsp_type r;
      longint signed dx, dy, dz;
      longint unsigned total, root_dist, top, m, ratio, inten;
      int slot;
      slot = v.vertex_index % VERTICES;
      dx = longint'(v.pos_x) - longint'(last_x[slot]);
      dy = longint'(v.pos_y) - longint'(last_y[slot]);
      dz = longint'(v.pos_z) - longint'(last_z[slot]);
      total = dx * dx + dy * dy + dz * dz;
      last_x[slot] = v.pos_x;
      last_y[slot] = v.pos_y;
      last_z[slot] = v.pos_z;
      root_dist = floor_root(total);
      top = (max_speed_q == 0) ? 1 : max_speed_q;
      m = (root_dist < top) ? root_dist : top;
      ratio = 0;
      if (m >= min_speed_q) begin
         ratio = (m * 65535) / top;
         if (ratio > 65535) ratio = 65535;
      end
      inten = (ratio * color_gain_q) / 65535;
      if (inten > 65535) inten = 65535;
      r.out_index = v.vertex_index;
      r.speed_ratio = ratio[RATIO_W-1:0];
      r.intensity = inten[RATIO_W-1:0];
      return r;
   endfunction

   // Driver: offers queued vertices, with random gaps while idling is on.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_intensities.push_back(motion_of(req_payload));
         end
         if (req_valid && req_stall) begin
            // Hold the stalled transaction.
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_vertices.size() > 0 &&
                      !(idling_on && $urandom_range(0, 9) == 0)) begin
            req_payload <= pending_vertices.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (idling_on && pending_vertices.size() > 0) send_gap <= $urandom_range(0, 6);
         end
      end
   end

   // Monitor: random stall bursts or a long hold-off, and checking of each result.
   always @(posedge clock) begin
      vmi_rsp_type want;
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 11) == 0) begin
            stall_burst <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_intensities.size() == 0) begin
               failed <= 1'b1;
               if (mismatch_count < 10)
                  $display("unexpected transaction: %h", rsp_payload);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_intensities.pop_front();
               if (want.out_index !== rsp_payload.out_index ||
                   want.speed_ratio !== rsp_payload.speed_ratio ||
                   want.intensity !== rsp_payload.intensity) begin
                  failed <= 1'b1;
                  if (mismatch_count < 10)
                     $display("mismatch: index %0d/%0d ratio %0d/%0d intensity %0d/%0d",
                              want.out_index, rsp_payload.out_index,
                              want.speed_ratio, rsp_payload.speed_ratio,
                              want.intensity, rsp_payload.intensity);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] any_coord();
      case ($urandom_range(0, 4))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return COORD_W'($urandom);
         default: return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   function automatic vmi_req_type make_vertex(int idx, logic signed [COORD_W-1:0] x,
                                               logic signed [COORD_W-1:0] y,
                                               logic signed [COORD_W-1:0] z);
      vmi_req_type v;
      v.vertex_index = IDX_W'(idx);
      v.pos_x = x;
      v.pos_y = y;
      v.pos_z = z;
      return v;
   endfunction

   // Nearby move of a vertex, so that distances land around the speed limits.
   function automatic vmi_req_type nudge(int idx, int span);
      int s;
      s = idx % VERTICES;
      return make_vertex(idx,
         last_x_plan[s] + COORD_W'($signed($urandom_range(0, 2 * span)) - span),
         last_y_plan[s] + COORD_W'($signed($urandom_range(0, 2 * span)) - span),
         last_z_plan[s] + COORD_W'($signed($urandom_range(0, 2 * span)) - span));
   endfunction

   task automatic plan(vmi_req_type v);
      int s;
      s = v.vertex_index % VERTICES;
      last_x_plan[s] = v.pos_x;
      last_y_plan[s] = v.pos_y;
      last_z_plan[s] = v.pos_z;
      pending_vertices.push_back(v);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_MAX_SPEED: max_speed_q = value;
         REG_MIN_SPEED: min_speed_q = value;
         REG_COLOR_GAIN: color_gain_q = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_vertices.size() > 0 || req_valid || expected_intensities.size() > 0)
         @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic random_phase(int count, int span);
      int idx;
      repeat (count) begin
         idx = (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63));
         if ($urandom_range(0, 9) < 8) plan(nudge(idx, span));
         else plan(make_vertex(idx, any_coord(), any_coord(), any_coord()));
      end
   endtask

   initial begin
      max_speed_q = 24'd2560;
      min_speed_q = 24'd128;
      color_gain_q = 16'd256;
      for (int i = 0; i < VERTICES; i++) begin
         last_x[i] = '0; last_y[i] = '0; last_z[i] = '0;
         last_x_plan[i] = '0; last_y_plan[i] = '0; last_z_plan[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of coordinates and indexes, zero move, below threshold.
      plan(make_vertex(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
      plan(make_vertex(0, 24'sh800000, 24'sh800000, 24'sh800000));
      plan(make_vertex(0, 24'sh800000, 24'sh800000, 24'sh800000));
      plan(make_vertex(4095, 24'sh000050, '0, '0));
      plan(make_vertex(4095, 24'sh000050, 24'sh000080, '0));
      plan(make_vertex(7, 24'sh000A00, '0, '0));
      plan(make_vertex(7, 24'sh000A00, 24'sh000500, 24'sh000500));
      plan(make_vertex(2048, 24'sh555555, 24'shAAAAAA, 24'sh123456));
      plan(make_vertex(1365, 24'shAAAAAA, 24'sh555555, 24'shFEDCBA));
      plan(make_vertex(2730, '0, '0, 24'sh00007F));
      drain();

      // Zero max_speed behaves as one; full gain.
      write_reg(REG_MAX_SPEED, 24'd0);
      write_reg(REG_MIN_SPEED, 24'd0);
      write_reg(REG_COLOR_GAIN, 24'h00FFFF);
      plan(make_vertex(9, '0, '0, '0));
      plan(make_vertex(9, '0, '0, 24'sh000001));
      plan(make_vertex(10, 24'sh7FFFFF, '0, 24'sh800000));
      random_phase(100, 4);
      drain();

      // Largest limits and zero gain.
      write_reg(REG_MAX_SPEED, 24'hFFFFFF);
      write_reg(REG_MIN_SPEED, 24'hFFFFFF);
      write_reg(REG_COLOR_GAIN, 24'd0);
      random_phase(150, 4000000);
      drain();

      // Long receiver hold-off while the sender keeps offering.
      write_reg(REG_MAX_SPEED, 24'd1000);
      write_reg(REG_MIN_SPEED, 24'd200);
      write_reg(REG_COLOR_GAIN, 24'h000300);
      hold_cycles = 300;
      random_phase(300, 900);
      drain();

      // Reset values again, then a run whose last vertices go without idling.
      write_reg(REG_MAX_SPEED, 24'd2560);
      write_reg(REG_MIN_SPEED, 24'd128);
      write_reg(REG_COLOR_GAIN, 24'd256);
      random_phase(490, 3000);
      while (pending_vertices.size() > NOISE_TAIL) @(posedge clock);
      idling_on = 1'b0;
      drain();

      if (!failed) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

`default_nettype wire
